@@ design/pqls_pkg.sv @@
// Shared types and codes for the linear-scan priority queue.
// No dependencies; the design top, pqls_mem and pqls_ctrl import this package.
`default_nettype none

package pqls_pkg;

  // Default number of entries the queue can hold.
  localparam int CAPACITY_DEF = 128;

  // Request codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_INSERTED    = 2'd0;
  localparam logic [1:0] ST_INSERT_FULL = 2'd1;
  localparam logic [1:0] ST_REMOVED     = 2'd2;
  localparam logic [1:0] ST_REMOVE_EMPT = 2'd3;

  // One stored entry.
  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] value;
  } entry_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [7:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } result_t;

endpackage

`default_nettype wire

@@ design/pqls_req_if.sv @@
// Request channel of the priority queue: valid/ready plus request fields.
// Stands alone; uses no package.
`default_nettype none

interface pqls_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] item_value;
  logic signed [15:0] item_priority;

  modport source (output valid, req_type, item_value, item_priority, input ready);
  modport sink (input valid, req_type, item_value, item_priority, output ready);
endinterface

`default_nettype wire

@@ design/pqls_rsp_if.sv @@
// Result channel of the priority queue: valid/ready plus result fields.
// Stands alone; uses no package.
`default_nettype none

interface pqls_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic [7:0]         entry_count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, status, removed_value, entry_count, is_empty, is_full,
                  input ready);
  modport sink (input valid, status, removed_value, entry_count, is_empty, is_full,
                output ready);
endinterface

`default_nettype wire

@@ design/priority_queue_linear_scan_top.sv @@
// Priority queue over an unsorted entry store with a linear-scan remove.
//
// Channels: req (sink) carries req_type, item_value and item_priority; rsp
// (source) carries status, removed_value, entry_count, is_empty and is_full.
// Both use valid/ready; an item moves on a clock edge with both high.
// Every request gives exactly one result item.
// Timing: one request is worked on at a time; req.ready is high only while
// the sequencer is idle. An insert or a refused request goes straight to the
// result state and shows its result when the output register takes it.
// A remove on n held entries reads the store once per cycle through its
// single read port for the maximum scan, then moves each later entry down
// one slot, and then shows its result. Ties go to the earliest-inserted
// entry.
// Reset (rst, synchronous) empties the queue at once; no clearing pass is
// run over the store. A stalled receiver holds the result in the output
// register; the next request is accepted meanwhile, but its result waits
// until the register is free.
// Depends on pqls_pkg, pqls_req_if, pqls_rsp_if, pqls_mem and pqls_ctrl.
`default_nettype none

module priority_queue_linear_scan_top #(
  parameter int CAPACITY = pqls_pkg::CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pqls_req_if.sink    req,
  pqls_rsp_if.source  rsp
);
  import pqls_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          res_free;
  logic          res_load;
  result_t       res;
  result_t       out_reg;
  logic          out_valid;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  pqls_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_free  (res_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  pqls_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: free when empty or being taken this cycle.
  assign res_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_reg <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_reg.status;
  assign rsp.removed_value = out_reg.removed_value;
  assign rsp.entry_count   = out_reg.entry_count;
  assign rsp.is_empty      = out_reg.is_empty;
  assign rsp.is_full       = out_reg.is_full;

endmodule

`default_nettype wire

@@ design/pqls_mem.sv @@
// Entry store of the priority queue: one write port, one registered read port.
// Depends on pqls_pkg for the entry type.
`default_nettype none

module pqls_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  pqls_pkg::entry_t     wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output pqls_pkg::entry_t     rdata
);
  import pqls_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/pqls_ctrl.sv @@
// Sequencer and shared compare unit of the priority queue.
// Scans the entry store for the maximum, then shifts later entries down.
// Depends on pqls_pkg, pqls_req_if and the pqls_mem port set.
`default_nettype none

module pqls_ctrl #(
  parameter int CAPACITY = pqls_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  pqls_req_if.sink           req,
  input  wire logic          res_free,
  output logic               res_load,
  output pqls_pkg::result_t  res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output pqls_pkg::entry_t   mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  pqls_pkg::entry_t   mem_rdata
);
  import pqls_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

  logic [1:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic               pend, pend_next;
  logic [CW-1:0]      pend_idx, pend_idx_next;
  logic signed [15:0] best_prio, best_prio_next;
  logic signed [31:0] best_val, best_val_next;
  logic [CW-1:0]      best_pos, best_pos_next;
  logic [1:0]         res_status, res_status_next;
  logic signed [31:0] res_val, res_val_next;
  logic [CW-1:0]      pend_dst;
  logic [CW+7:0]      count_ext;
  logic               accept;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign pend_dst  = pend_idx - CW'(1);
  assign count_ext = (CW+8)'(count);

  // Result fields follow the count held after the request.
  always_comb begin
    res.status        = res_status;
    res.removed_value = res_val;
    res.entry_count   = (count_ext > (CW+8)'(255)) ? 8'hFF : count_ext[7:0];
    res.is_empty      = (count == '0);
    res.is_full       = (count == CAP_W);
    res_load          = (state == S_RESP) && res_free;
  end

  // Sequencer, read pipeline and shared compare unit.
  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    pend_next       = 1'b0;
    pend_idx_next   = idx;
    best_prio_next  = best_prio;
    best_val_next   = best_val;
    best_pos_next   = best_pos;
    res_status_next = res_status;
    res_val_next    = res_val;
    mem_we          = 1'b0;
    mem_waddr       = count[AW-1:0];
    mem_wdata       = '{prio: req.item_priority, value: req.item_value};
    mem_re          = 1'b0;
    mem_raddr       = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_val_next = '0;
          if (req.req_type == REQ_INSERT) begin
            state_next = S_RESP;
            if (count == CAP_W) begin
              res_status_next = ST_INSERT_FULL;
            end else begin
              mem_we          = 1'b1;
              count_next      = count + CW'(1);
              res_status_next = ST_INSERTED;
            end
          end else if (count == '0) begin
            state_next      = S_RESP;
            res_status_next = ST_REMOVE_EMPT;
          end else begin
            state_next = S_SCAN;
            idx_next   = '0;
          end
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; compare the entry that arrives.
        if (idx < count) begin
          mem_re    = 1'b1;
          pend_next = 1'b1;
          idx_next  = idx + CW'(1);
        end
        if (pend) begin
          if ((pend_idx == '0) || (mem_rdata.prio > best_prio)) begin
            best_prio_next = mem_rdata.prio;
            best_val_next  = mem_rdata.value;
            best_pos_next  = pend_idx;
          end
        end
        if (!(idx < count) && !pend) begin
          state_next = S_SHIFT;
          idx_next   = best_pos + CW'(1);
        end
      end

      S_SHIFT: begin
        // Read the entry behind the gap, write it one slot lower next cycle.
        if (idx < count) begin
          mem_re    = 1'b1;
          pend_next = 1'b1;
          idx_next  = idx + CW'(1);
        end
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_dst[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (!(idx < count) && !pend) begin
          state_next      = S_RESP;
          count_next      = count - CW'(1);
          res_status_next = ST_REMOVED;
          res_val_next    = best_val;
        end
      end

      S_RESP: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pend_idx   <= pend_idx_next;
    best_prio  <= best_prio_next;
    best_val   <= best_val_next;
    best_pos   <= best_pos_next;
    res_status <= res_status_next;
    res_val    <= res_val_next;
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_W)
    else $error("entry count above capacity");

  // The count moves by at most one per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count)) || (count == $past(count) + CW'(1)) ||
             (count == $past(count) - CW'(1)))
    else $error("entry count jumped");

  // The scan for the maximum never writes the store.
  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !mem_we)
    else $error("store written during scan");

  // A remove on a non-empty queue starts the scan.
  a_remove_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.req_type == REQ_REMOVE) && (count != '0)) |=> (state == S_SCAN))
    else $error("remove did not start a scan");

  // Handing off the result returns the sequencer to idle.
  a_resp_idle: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (state == S_IDLE))
    else $error("sequencer not idle after result");

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for priority_queue_linear_scan_top.
// Predicts every result from its own copy of the queue contents and checks it.
// Depends on pqls_pkg, pqls_req_if, pqls_rsp_if and the design top.
`timescale 1ns / 1ps

module testbench;
  import pqls_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;
  // Longest remove plus the longest gap on either side, taken many times over.
  localparam int IDLE_LIMIT = 10 * (2 * QUEUE_DEPTH + 32);
  localparam int DRAIN_WAIT = 2 * QUEUE_DEPTH + 16;

  logic clk = 1'b0;
  logic rst;

  pqls_req_if req_ch ();
  pqls_rsp_if rsp_ch ();

  priority_queue_linear_scan_top #(
    .CAPACITY(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predicted queue contents, kept in arrival order.
  logic signed [31:0] model_value[QUEUE_DEPTH];
  logic signed [15:0] model_prio[QUEUE_DEPTH];
  int                 model_count;

  result_t pending_results[$];
  int      error_count;
  int      idle_cycles;
  bit      no_idle;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Updates the predicted queue for one request and returns its result.
  function automatic result_t apply_request(input logic kind, input logic signed [31:0] value,
                                            input logic signed [15:0] prio);
    result_t r;
    int      best;
    int      i;
    r = '0;
    if (kind == REQ_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        r.status = ST_INSERT_FULL;
      end else begin
        model_value[model_count] = value;
        model_prio[model_count] = prio;
        model_count++;
        r.status = ST_INSERTED;
      end
    end else if (model_count == 0) begin
      r.status = ST_REMOVE_EMPT;
    end else begin
      // A strict comparison keeps the earliest entry among equal priorities.
      best = 0;
      for (i = 1; i < model_count; i++) begin
        if (model_prio[i] > model_prio[best]) best = i;
      end
      r.removed_value = model_value[best];
      for (i = best; i < model_count - 1; i++) begin
        model_value[i] = model_value[i + 1];
        model_prio[i] = model_prio[i + 1];
      end
      model_count--;
      r.status = ST_REMOVED;
    end
    r.entry_count = (model_count > 255) ? 8'd255 : 8'(model_count);
    r.is_empty = (model_count == 0);
    r.is_full = (model_count >= QUEUE_DEPTH);
    return r;
  endfunction

  // Sends one request item; called and returning at a falling edge.
  task automatic send_request(input logic kind, input logic signed [31:0] value,
                              input logic signed [15:0] prio);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.item_value <= value;
    req_ch.item_priority <= prio;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_request(kind, value, prio));
    @(negedge clk);
  endtask

  // Result side: random stalls before each item, then check it on acceptance.
  initial begin
    result_t want;
    int      stall;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      if (pending_results.size() == 0) begin
        $error("unexpected result item: status %0d", rsp_ch.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, got %0d", want.removed_value,
                 rsp_ch.removed_value);
          error_count++;
        end
        if (rsp_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_ch.entry_count);
          error_count++;
        end
        if (rsp_ch.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
          error_count++;
        end
        if (rsp_ch.is_full !== want.is_full) begin
          $error("is_full: expected %0d, got %0d", want.is_full, rsp_ch.is_full);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Ends the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAIL priority_queue_linear_scan_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Removes on an empty queue are refused and leave it empty.
  task automatic test_empty_remove();
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_REMOVE, -32'sd1, -16'sd1);
  endtask

  // Extreme values and priorities come back out in priority order.
  task automatic test_field_extremes();
    send_request(REQ_INSERT, 32'sh8000_0000, 16'sh8000);
    send_request(REQ_INSERT, 32'sd0, 16'sd0);
    send_request(REQ_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
    send_request(REQ_INSERT, -32'sd1, -16'sd1);
    send_request(REQ_INSERT, 32'sh5555_AAAA, 16'sd1);
    // Fields of a remove are ignored, so drive them with nonzero patterns.
    send_request(REQ_REMOVE, 32'shFFFF_FFFF, 16'shFFFF);
    send_request(REQ_REMOVE, 32'shAAAA_5555, 16'sh7FFF);
    send_request(REQ_REMOVE, 32'sd0, 16'sh8000);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
  endtask

  // Equal priorities are served in arrival order.
  task automatic test_tie_order();
    send_request(REQ_INSERT, 32'sd11, 16'sd5);
    send_request(REQ_INSERT, 32'sd22, 16'sd9);
    send_request(REQ_INSERT, 32'sd33, 16'sd5);
    send_request(REQ_INSERT, 32'sd44, 16'sd9);
    send_request(REQ_INSERT, 32'sd55, 16'sd9);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_INSERT, 32'sd66, 16'sd5);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
    send_request(REQ_REMOVE, 32'sd0, 16'sd0);
  endtask

  // Fill to capacity, get refused, then drain down past empty.
  task automatic test_fill_and_drain();
    while (model_count < QUEUE_DEPTH) begin
      send_request(REQ_INSERT, $urandom, 16'($urandom));
    end
    send_request(REQ_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
    send_request(REQ_INSERT, 32'sh8000_0000, 16'sh8000);
    while (model_count > 0) begin
      send_request(REQ_REMOVE, $urandom, 16'($urandom));
    end
    send_request(REQ_REMOVE, $urandom, 16'($urandom));
  endtask

  // Episodes of random requests that push the fill level up and down.
  task automatic test_random_mix(input int item_total);
    int  sent;
    int  episode_len;
    int  insert_pct;
    bit  tie_heavy;
    logic kind;
    logic signed [15:0] prio;
    sent = 0;
    while (sent < item_total) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 15;
        1: insert_pct = 50;
        default: insert_pct = 85;
      endcase
      episode_len = $urandom_range(30, 100);
      tie_heavy = ($urandom_range(0, 3) == 0);
      no_idle = ($urandom_range(0, 4) == 0);
      repeat (episode_len) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        // A narrow priority range makes ties common.
        prio = tie_heavy ? 16'(int'($urandom_range(0, 3)) - 1) : 16'($urandom);
        send_request(kind, $urandom, prio);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.item_value = '0;
    req_ch.item_priority = '0;
    rsp_ch.ready = 1'b0;
    model_count = 0;
    error_count = 0;
    no_idle = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_remove();
    test_field_extremes();
    test_tie_order();
    test_fill_and_drain();
    test_random_mix(840);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS priority_queue_linear_scan_top");
    end else begin
      $display("FAIL priority_queue_linear_scan_top");
    end
    $finish;
  end

endmodule
